// ----- rtl/core/vbm_pkg.sv -----
package vbm_pkg;

    localparam int MAX_VOXELS = 32768;
    localparam int ADDR_W     = $clog2(MAX_VOXELS);
    // count must hold MAX_VOXELS + 1 to mark an overflowing load
    localparam int CNT_W      = 16;
    localparam int VAL_W      = 8;
    localparam int DIM_W      = 11;
    localparam int IDX_W      = 10;
    localparam int XY_W       = 2 * DIM_W;
    localparam int PROD_W     = 3 * DIM_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SIZE_XY,
        ST_SIZE_XYZ,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_ready;
        logic mul_xy;
        logic mul_xyz;
        logic check;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last_fire;
        logic size_err;
        logic scan_last;
        logic out_busy;
    } t_status;

    function automatic logic [IDX_W-1:0] sat_idx(input logic [DIM_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = (v[DIM_W-1:IDX_W] != '0) ? {IDX_W{1'b1}} : v[IDX_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/vbm_if.sv -----
interface vbm_voxel_if;
    logic                      valid;
    logic                      ready;
    logic [vbm_pkg::VAL_W-1:0] voxel_value;
    logic                      last_voxel;

    modport source (output valid, output voxel_value, output last_voxel, input ready);
    modport sink   (input valid, input voxel_value, input last_voxel, output ready);
endinterface

interface vbm_result_if;
    logic                      valid;
    logic                      ready;
    logic [vbm_pkg::CNT_W-1:0] ones_count;
    logic [vbm_pkg::CNT_W-1:0] zeros_count;
    logic [vbm_pkg::IDX_W-1:0] low_x;
    logic [vbm_pkg::IDX_W-1:0] high_x;
    logic [vbm_pkg::IDX_W-1:0] low_y;
    logic [vbm_pkg::IDX_W-1:0] high_y;
    logic [vbm_pkg::IDX_W-1:0] low_z;
    logic [vbm_pkg::IDX_W-1:0] high_z;
    logic                      size_error;

    modport source (
        output valid, output ones_count, output zeros_count,
        output low_x, output high_x, output low_y, output high_y,
        output low_z, output high_z, output size_error,
        input ready
    );
    modport sink (
        input valid, input ones_count, input zeros_count,
        input low_x, input high_x, input low_y, input high_y,
        input low_z, input high_z, input size_error,
        output ready
    );
endinterface

// ----- rtl/core/vbm_ctrl.sv -----
module vbm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vbm_pkg::t_status i_status,
    output vbm_pkg::t_cmd    o_cmd
);

    vbm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vbm_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            vbm_pkg::ST_LOAD: begin
                o_cmd.load_ready = 1'b1;
                if (i_status.last_fire) begin
                    n_state = vbm_pkg::ST_SIZE_XY;
                end
            end
            vbm_pkg::ST_SIZE_XY: begin
                o_cmd.mul_xy = 1'b1;
                n_state      = vbm_pkg::ST_SIZE_XYZ;
            end
            vbm_pkg::ST_SIZE_XYZ: begin
                o_cmd.mul_xyz = 1'b1;
                n_state       = vbm_pkg::ST_CHECK;
            end
            vbm_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.size_err ? vbm_pkg::ST_FINISH : vbm_pkg::ST_SCAN;
            end
            vbm_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = vbm_pkg::ST_DRAIN;
                end
            end
            vbm_pkg::ST_DRAIN: begin
                // last read word is still being evaluated
                n_state = vbm_pkg::ST_FINISH;
            end
            vbm_pkg::ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = vbm_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = vbm_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ----- rtl/core/vbm_datapath.sv -----
module vbm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vbm_pkg::DIM_W-1:0]     i_cfg_data,
    input  vbm_pkg::t_cmd                 i_cmd,
    output vbm_pkg::t_status              o_status,
    vbm_voxel_if.sink                     i_voxel,
    vbm_result_if.source                  o_result
);

    localparam logic [vbm_pkg::CNT_W-1:0] MAX_CNT = vbm_pkg::CNT_W'(vbm_pkg::MAX_VOXELS);

    logic [vbm_pkg::DIM_W-1:0]  r_x_size, r_y_size, r_z_size;
    logic [vbm_pkg::VAL_W-1:0]  r_mem [0:vbm_pkg::MAX_VOXELS-1];
    logic [vbm_pkg::CNT_W-1:0]  r_count;
    logic [vbm_pkg::VAL_W-1:0]  r_peak;
    logic [vbm_pkg::XY_W-1:0]   r_xy;
    logic [vbm_pkg::PROD_W-1:0] r_xyz;
    logic                       r_err;

    // scan address stage
    logic [vbm_pkg::ADDR_W-1:0] r_addr;
    logic [vbm_pkg::DIM_W-1:0]  r_x, r_y, r_z;
    // read data stage
    logic                       r_p_vld;
    logic [vbm_pkg::VAL_W-1:0]  r_rd_data;
    logic [vbm_pkg::DIM_W-1:0]  r_p_x, r_p_y, r_p_z;
    // accumulators
    logic [vbm_pkg::CNT_W-1:0]  r_ones, r_zeros;
    logic [vbm_pkg::DIM_W-1:0]  r_lx, r_hx, r_ly, r_hy, r_lz, r_hz;

    logic r_out_vld;

    logic fire;
    logic is_one;
    logic x_wrap, y_wrap;

    assign fire          = i_voxel.valid & i_cmd.load_ready;
    assign i_voxel.ready = i_cmd.load_ready;

    assign o_status.last_fire = fire & i_voxel.last_voxel;
    assign o_status.size_err  = (r_count > MAX_CNT)
                              || (vbm_pkg::PROD_W'(r_count) != r_xyz);
    assign o_status.scan_last = (vbm_pkg::CNT_W'(r_addr) + vbm_pkg::CNT_W'(1)) == r_count;
    assign o_status.out_busy  = r_out_vld & ~o_result.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= vbm_pkg::DIM_RESET;
            r_y_size <= vbm_pkg::DIM_RESET;
            r_z_size <= vbm_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vbm_pkg::CFG_X_SIZE: r_x_size <= i_cfg_data;
                vbm_pkg::CFG_Y_SIZE: r_y_size <= i_cfg_data;
                vbm_pkg::CFG_Z_SIZE: r_z_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // load count and peak tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_peak  <= '0;
        end else if (i_cmd.finish) begin
            r_count <= '0;
            r_peak  <= '0;
        end else if (fire) begin
            if (r_count <= MAX_CNT) begin
                r_count <= r_count + vbm_pkg::CNT_W'(1);
            end
            if (i_voxel.voxel_value > r_peak) begin
                r_peak <= i_voxel.voxel_value;
            end
        end
    end

    // voxel store: written during load, read during scan
    always_ff @(posedge i_clk) begin
        if (fire && r_count < MAX_CNT) begin
            r_mem[r_count[vbm_pkg::ADDR_W-1:0]] <= i_voxel.voxel_value;
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // expected size, one multiply per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_xy) begin
            r_xy <= r_x_size * r_y_size;
        end
        if (i_cmd.mul_xyz) begin
            r_xyz <= r_xy * r_z_size;
        end
        if (i_cmd.check) begin
            r_err <= o_status.size_err;
        end
    end

    assign x_wrap = (r_x == r_x_size - vbm_pkg::DIM_W'(1));
    assign y_wrap = (r_y == r_y_size - vbm_pkg::DIM_W'(1));

    // address and coordinate walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_addr <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
        end else if (i_cmd.scan_step) begin
            r_addr <= r_addr + vbm_pkg::ADDR_W'(1);
            if (x_wrap) begin
                r_x <= '0;
                if (y_wrap) begin
                    r_y <= '0;
                    r_z <= r_z + vbm_pkg::DIM_W'(1);
                end else begin
                    r_y <= r_y + vbm_pkg::DIM_W'(1);
                end
            end else begin
                r_x <= r_x + vbm_pkg::DIM_W'(1);
            end
        end
        r_p_x <= r_x;
        r_p_y <= r_y;
        r_p_z <= r_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.scan_step;
        end
    end

    // threshold at half the peak, kept exact by doubling the voxel
    assign is_one = {r_rd_data, 1'b0} > {1'b0, r_peak};

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_ones  <= '0;
            r_zeros <= '0;
            r_lx    <= r_x_size - vbm_pkg::DIM_W'(1);
            r_ly    <= r_y_size - vbm_pkg::DIM_W'(1);
            r_lz    <= r_z_size - vbm_pkg::DIM_W'(1);
            r_hx    <= '0;
            r_hy    <= '0;
            r_hz    <= '0;
        end else if (r_p_vld) begin
            if (is_one) begin
                r_ones <= r_ones + vbm_pkg::CNT_W'(1);
                if (r_p_x < r_lx) r_lx <= r_p_x;
                if (r_p_x > r_hx) r_hx <= r_p_x;
                if (r_p_y < r_ly) r_ly <= r_p_y;
                if (r_p_y > r_hy) r_hy <= r_p_y;
                if (r_p_z < r_lz) r_lz <= r_p_z;
                if (r_p_z > r_hz) r_hz <= r_p_z;
            end else begin
                r_zeros <= r_zeros + vbm_pkg::CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_err) begin
                o_result.ones_count  <= '0;
                o_result.zeros_count <= '0;
                o_result.low_x       <= '0;
                o_result.high_x      <= '0;
                o_result.low_y       <= '0;
                o_result.high_y      <= '0;
                o_result.low_z       <= '0;
                o_result.high_z      <= '0;
                o_result.size_error  <= 1'b1;
            end else begin
                o_result.ones_count  <= r_ones;
                o_result.zeros_count <= r_zeros;
                o_result.low_x       <= vbm_pkg::sat_idx(r_lx);
                o_result.high_x      <= vbm_pkg::sat_idx(r_hx);
                o_result.low_y       <= vbm_pkg::sat_idx(r_ly);
                o_result.high_y      <= vbm_pkg::sat_idx(r_hy);
                o_result.low_z       <= vbm_pkg::sat_idx(r_lz);
                o_result.high_z      <= vbm_pkg::sat_idx(r_hz);
                o_result.size_error  <= 1'b0;
            end
        end
    end

    assign o_result.valid = r_out_vld;

endmodule

// ----- rtl/core/voxel_binarize_measure.sv -----
// channel    dir  payload                                        handshake
// i_voxel    in   voxel_value[7:0], last_voxel                   valid/ready
// o_result   out  ones/zeros_count[15:0], box 6x[9:0], size_error valid/ready
// i_cfg_*    in   idx[1:0] (x,y,z size), data[10:0]              write enable only
//
// load: one voxel per cycle into a 32768 x 8 store, peak tracked on the fly
// close: size product and check (states SIZE_XY, SIZE_XYZ, CHECK), then
// a pass reading the store one voxel per cycle (single read port), then
// DRAIN and FINISH to the result register; a size error skips the read pass
// reset clears control state and restores sizes to 32; the store is not cleared
// the result register holds while output is stalled; loading of the next
// volume goes on meanwhile, a new result waits for the register to free
module voxel_binarize_measure (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vbm_pkg::DIM_W-1:0]     i_cfg_data,
    vbm_voxel_if.sink                     i_voxel,
    vbm_result_if.source                  o_result
);

    vbm_pkg::t_cmd    cmd;
    vbm_pkg::t_status status;

    vbm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vbm_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_voxel    (i_voxel),
        .o_result   (o_result)
    );

endmodule

// ----- rtl/core/vbm_checker.sv -----
module vbm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_in_last,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [vbm_pkg::CNT_W-1:0] i_ones,
    input logic [vbm_pkg::CNT_W-1:0] i_zeros,
    input logic [vbm_pkg::IDX_W-1:0] i_low_x,
    input logic [vbm_pkg::IDX_W-1:0] i_high_x,
    input logic [vbm_pkg::IDX_W-1:0] i_low_y,
    input logic [vbm_pkg::IDX_W-1:0] i_high_y,
    input logic [vbm_pkg::IDX_W-1:0] i_low_z,
    input logic [vbm_pkg::IDX_W-1:0] i_high_z,
    input logic                      i_err
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // closing a volume stops input for the closing pass
    a_close_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input taken right after last voxel");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_err |-> i_ones == '0 && i_zeros == '0
            && i_low_x == '0 && i_high_x == '0 && i_low_y == '0
            && i_high_y == '0 && i_low_z == '0 && i_high_z == '0)
        else $error("size error result carries data");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_err && i_ones != '0 |->
            i_low_x <= i_high_x && i_low_y <= i_high_y && i_low_z <= i_high_z)
        else $error("bounding box inverted with ones present");

    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_err && i_ones == '0 |->
            i_high_x == '0 && i_high_y == '0 && i_high_z == '0 && i_zeros != '0)
        else $error("empty volume box not at defaults");

endmodule

bind voxel_binarize_measure vbm_checker u_vbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_voxel.valid),
    .i_in_ready  (i_voxel.ready),
    .i_in_last   (i_voxel.last_voxel),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_ones      (o_result.ones_count),
    .i_zeros     (o_result.zeros_count),
    .i_low_x     (o_result.low_x),
    .i_high_x    (o_result.high_x),
    .i_low_y     (o_result.low_y),
    .i_high_y    (o_result.high_y),
    .i_low_z     (o_result.low_z),
    .i_high_z    (o_result.high_z),
    .i_err       (o_result.size_error)
);

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vbm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [CNT_W-1:0] ones_count;
        logic [CNT_W-1:0] zeros_count;
        logic [IDX_W-1:0] low_x;
        logic [IDX_W-1:0] high_x;
        logic [IDX_W-1:0] low_y;
        logic [IDX_W-1:0] high_y;
        logic [IDX_W-1:0] low_z;
        logic [IDX_W-1:0] high_z;
        logic             size_error;
    } t_volume_summary;

    typedef enum int {
        FILL_UNIFORM,
        FILL_SPARSE,
        FILL_FLAT,
        FILL_EDGE,
        FILL_ZERO,
        FILL_TAIL
    } t_fill_mode;

    // mirrors the volume store, peak and sizes; holds the summaries still due
    class volume_tracker;
        logic [VAL_W-1:0] store [MAX_VOXELS];
        int unsigned      peak;
        int unsigned      loaded;
        int unsigned      dims [3];
        t_volume_summary  summary_q [$];
        int unsigned      mismatches;
        int unsigned      checked;

        function new();
            peak       = 0;
            loaded     = 0;
            dims       = '{32, 32, 32};
            mismatches = 0;
            checked    = 0;
        endfunction

        function void record_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                CFG_X_SIZE: dims[0] = data;
                CFG_Y_SIZE: dims[1] = data;
                CFG_Z_SIZE: dims[2] = data;
                default: ;
            endcase
        endfunction

        function logic [IDX_W-1:0] clip_index(int unsigned v);
            return (v >= (1 << IDX_W)) ? '1 : IDX_W'(v);
        endfunction

        function void note_voxel(logic [VAL_W-1:0] v, bit last);
            t_volume_summary   s;
            longint unsigned   product;
            int unsigned       lx, ly, lz, hx, hy, hz, x, y, z, ones, zeros;
            if (loaded < MAX_VOXELS) store[loaded] = v;
            if (loaded <= MAX_VOXELS) loaded++;
            if (v > peak) peak = v;
            if (!last) return;
            product = dims[0];
            product = product * dims[1] * dims[2];
            s = '0;
            if (loaded > MAX_VOXELS || loaded != product) begin
                s.size_error = 1'b1;
            end else begin
                lx = dims[0] - 1;
                ly = dims[1] - 1;
                lz = dims[2] - 1;
                hx = 0; hy = 0; hz = 0;
                x = 0; y = 0; z = 0;
                ones = 0; zeros = 0;
                for (int i = 0; i < loaded; i++) begin
                    // half-max test kept in integers
                    if (2 * int'(store[i]) > int'(peak)) begin
                        ones++;
                        if (x < lx) lx = x;
                        if (x > hx) hx = x;
                        if (y < ly) ly = y;
                        if (y > hy) hy = y;
                        if (z < lz) lz = z;
                        if (z > hz) hz = z;
                    end else begin
                        zeros++;
                    end
                    x++;
                    if (x >= dims[0]) begin
                        x = 0;
                        y++;
                        if (y >= dims[1]) begin
                            y = 0;
                            z++;
                        end
                    end
                end
                s.ones_count  = (ones > 16'hFFFF) ? '1 : CNT_W'(ones);
                s.zeros_count = (zeros > 16'hFFFF) ? '1 : CNT_W'(zeros);
                s.low_x  = clip_index(lx);
                s.high_x = clip_index(hx);
                s.low_y  = clip_index(ly);
                s.high_y = clip_index(hy);
                s.low_z  = clip_index(lz);
                s.high_z = clip_index(hz);
            end
            summary_q.push_back(s);
            peak   = 0;
            loaded = 0;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("mismatch at %0t, summary %0d: %s", $time, checked, msg);
        endtask

        task compare_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_summary(t_volume_summary got);
            t_volume_summary want;
            if (summary_q.size() == 0) begin
                report_mismatch("result transfer with no summary pending");
                return;
            end
            want = summary_q.pop_front();
            compare_field("ones_count", got.ones_count, want.ones_count);
            compare_field("zeros_count", got.zeros_count, want.zeros_count);
            compare_field("low_x", got.low_x, want.low_x);
            compare_field("high_x", got.high_x, want.high_x);
            compare_field("low_y", got.low_y, want.low_y);
            compare_field("high_y", got.high_y, want.high_y);
            compare_field("low_z", got.low_z, want.low_z);
            compare_field("high_z", got.high_z, want.high_z);
            compare_field("size_error", got.size_error, want.size_error);
            checked++;
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]     cfg_data;

    vbm_voxel_if  voxel_ch ();
    vbm_result_if result_ch ();

    voxel_binarize_measure u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_voxel    (voxel_ch),
        .o_result   (result_ch)
    );

    volume_tracker board = new();
    bit            quiet;
    bit            hold_req;
    int unsigned   random_sent;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap(bit bulk);
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (bulk) return (r < 90) ? 0 : 1;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 16);
    endfunction

    task automatic send_voxel(logic [VAL_W-1:0] v, bit last, int gap);
        if (gap > 0) begin
            voxel_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        voxel_ch.valid       <= 1'b1;
        voxel_ch.voxel_value <= v;
        voxel_ch.last_voxel  <= last;
        @(posedge i_clk);
        while (!voxel_ch.ready) @(posedge i_clk);
        board.note_voxel(v, last);
    endtask

    task automatic send_values(input logic [VAL_W-1:0] vals [$]);
        foreach (vals[i]) send_voxel(vals[i], i == vals.size() - 1, pick_gap(1'b0));
    endtask

    task automatic send_volume(int len, t_fill_mode mode, bit bulk);
        logic [VAL_W-1:0] v, p, c;
        p = VAL_W'($urandom_range(0, 255));
        c = ($urandom_range(0, 3) == 0) ? '0 : VAL_W'($urandom_range(1, 255));
        for (int i = 0; i < len; i++) begin
            case (mode)
                FILL_UNIFORM: v = VAL_W'($urandom_range(0, 255));
                FILL_SPARSE:  v = ($urandom_range(0, 99) < 85) ? '0 : VAL_W'($urandom_range(1, 255));
                FILL_FLAT:    v = c;
                FILL_EDGE: begin
                    // values around half of a chosen peak
                    case ($urandom_range(0, 3))
                        0: v = p;
                        1: v = p >> 1;
                        2: v = (p >> 1) + VAL_W'(1);
                        default: v = VAL_W'($urandom_range(0, p));
                    endcase
                end
                FILL_ZERO: v = '0;
                default: begin
                    // low values early so the ones sit late in the volume
                    v = (i < len * 11 / 20) ? VAL_W'($urandom_range(0, 40))
                                            : VAL_W'($urandom_range(0, 255));
                end
            endcase
            send_voxel(v, i == len - 1, pick_gap(bulk));
        end
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        board.record_dim(idx, data);
    endtask

    task automatic program_dims(int x, int y, int z);
        write_cfg(CFG_X_SIZE, DIM_W'(x));
        write_cfg(CFG_Y_SIZE, DIM_W'(y));
        write_cfg(CFG_Z_SIZE, DIM_W'(z));
        cfg_we <= 1'b0;
    endtask

    // block is idle once every summary is back and the close pass has settled
    task automatic finish_phase();
        voxel_ch.valid <= 1'b0;
        while (board.summary_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_side
        int              stall;
        bit              held;
        t_volume_summary got;
        stall = 0;
        held  = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                got.ones_count  = result_ch.ones_count;
                got.zeros_count = result_ch.zeros_count;
                got.low_x       = result_ch.low_x;
                got.high_x      = result_ch.high_x;
                got.low_y       = result_ch.low_y;
                got.high_y      = result_ch.high_y;
                got.low_z       = result_ch.low_z;
                got.high_z      = result_ch.high_z;
                got.size_error  = result_ch.size_error;
                board.check_summary(got);
            end
            if (hold_req && !held) begin
                // long hold so the next volumes back up and stall the input
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall > 0) begin
                result_ch.ready <= 1'b0;
                stall--;
            end else begin
                stall = pick_gap(1'b0);
                result_ch.ready <= (stall == 0);
            end
        end
    end

    initial begin : voxel_side
        int x, y, z, len, nvol, r, phase;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        voxel_ch.valid       <= 1'b0;
        voxel_ch.voxel_value <= '0;
        voxel_ch.last_voxel  <= 1'b0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        random_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single voxel against the reset sizes
        send_values('{8'd200});
        finish_phase();
        write_cfg(CFG_UNUSED, '1);
        program_dims(1, 1, 1);
        send_values('{8'd0});
        send_values('{8'd255});
        finish_phase();
        program_dims(2, 2, 2);
        send_values('{8'd127, 8'd128, 8'd0, 8'd255, 8'd1, 8'd200, 8'd127, 8'd128});
        finish_phase();
        // peak 254: 127 is exactly half and stays zero
        program_dims(3, 1, 2);
        send_values('{8'd127, 8'd254, 8'd0, 8'd0, 8'd128, 8'd127});
        finish_phase();
        program_dims(2, 1, 1);
        send_values('{8'd9, 8'd99, 8'd199});
        send_values('{8'd77});
        finish_phase();
        program_dims(0, 1, 1);
        send_values('{8'd5});
        finish_phase();
        program_dims(5, 2047, 2047);
        send_values('{8'd1, 8'd2, 8'd3});
        finish_phase();

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            quiet = (phase != 1) && ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 19);
            x = $urandom_range(1, 8);
            y = $urandom_range(1, 4);
            z = $urandom_range(1, 4);
            if (r == 0) begin
                case ($urandom_range(0, 2))
                    0: x = 0;
                    1: y = 0;
                    default: z = 0;
                endcase
            end else if (r < 4) begin
                x = 1; y = 1; z = 1;
                case ($urandom_range(0, 2))
                    0: x = $urandom_range(9, 40);
                    1: y = $urandom_range(9, 40);
                    default: z = $urandom_range(9, 40);
                endcase
            end
            program_dims(x, y, z);
            nvol = (phase == 1) ? 4 : $urandom_range(2, 5);
            for (int vol = 0; vol < nvol; vol++) begin
                len = x * y * z;
                if (len == 0) begin
                    len = $urandom_range(1, 4);
                end else if ($urandom_range(0, 99) < 15) begin
                    // short or long load
                    if (len > 1 && $urandom_range(0, 1) == 0)
                        len = $urandom_range(1, len - 1);
                    else
                        len = len + $urandom_range(1, 3);
                end
                send_volume(len, t_fill_mode'($urandom_range(0, 5)), 1'b0);
                random_sent += len;
                if (phase == 1 && vol == 0) hold_req = 1'b1;
            end
            finish_phase();
            phase++;
        end
        quiet = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.summary_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
